// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, suspended while arst_n is low.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/ubh_pkg.sv =====
// ----------------------------------------------------------------------------
// ubh_pkg
// Types and constants of the uniform-bin histogram engine.
// ----------------------------------------------------------------------------
package ubh_pkg;

	localparam int BINS      = 1024;
	localparam int IDX_W     = $clog2(BINS);
	localparam int NBIN_W    = IDX_W + 1;
	localparam int DATA_W    = 32;
	localparam int SCALED_W  = 48;
	localparam int EPROD_W   = IDX_W + DATA_W;
	localparam int CFG_IDX_W = 3;
	localparam int RIDX_W    = 10;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 80;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 3'd4;

	// function codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// reset values
	localparam logic [DATA_W-1:0] LOW_EDGE_RST    = 32'd0;
	localparam logic [DATA_W-1:0] HIGH_EDGE_RST   = 32'd65536;
	localparam logic [DATA_W-1:0] BIN_WIDTH_RST   = 32'd64;
	localparam logic [DATA_W-1:0] BIN_SCALE_RST   = 32'd1024;
	localparam logic [NBIN_W-1:0] BINS_IN_USE_RST = NBIN_W'(BINS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RANGE,
		ST_SCALE,
		ST_READ,
		ST_UPDATE,
		ST_EDGE
	} ubh_state_t;

endpackage

// ===== design/uniform_bin_histogram.sv =====
// ----------------------------------------------------------------------------
// uniform_bin_histogram
// Equal-width histogram: inserts count samples into a bin store, reads
// return a bin's count and lower edge.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  s_       in         s_tvalid / s_tready     s_tdata, s_tuser
//  m_       out        m_tvalid / m_tready     m_tdata, m_tuser
//  cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Each item runs through its steps in order after accept: range check,
//  32x32 scale multiply, count memory read, update and edge multiply, then
//  the output register. The next item is accepted only once the last has
//  left the final step. After reset a clearing pass zeroes all 1024 bins; items
//  wait, configuration writes are taken. A stalled result holds in the output
//  register; the next item is accepted and waits in the final step until it frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uniform_bin_histogram
	import ubh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [31:0] sample, [41:32] read_index, [47:42] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [9:0] bin_index, [41:10] bin_count, [73:42] bin_edge, [79:74] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// [0] hit
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]      cfg_data
);

	ubh_state_t state_q, state_d;

	logic signed [DATA_W-1:0] low_edge_q, high_edge_q;
	logic [DATA_W-1:0]        bin_width_q, bin_scale_q;
	logic [NBIN_W-1:0]        bins_in_use_q;
	logic [NBIN_W-1:0]        n_used;

	logic                     func_q;
	logic signed [DATA_W-1:0] sample_q;
	logic [RIDX_W-1:0]        rd_idx_q;
	logic                     in_range_q;
	logic [DATA_W-1:0]        diff_q;
	logic [2*DATA_W-1:0]      prod;
	logic [SCALED_W-1:0]      scaled_q;
	logic [IDX_W-1:0]         idx_d, idx_q;
	logic                     hit_d, hit_q;
	logic [DATA_W-1:0]        count_q, count_new;
	logic [EPROD_W-1:0]       eprod, eprod_q;
	logic [DATA_W-1:0]        edge_val;
	logic [IDX_W-1:0]         clr_q;

	logic [DATA_W-1:0]        bin_mem [BINS];
	logic [DATA_W-1:0]        rdata_q;
	logic                     mem_we;
	logic [IDX_W-1:0]         mem_waddr;
	logic [DATA_W-1:0]        mem_wdata;

	logic                     out_free, load_out, accept;
	logic                     out_valid_q, out_hit_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic [DATA_W-1:0]        out_count_q, out_edge_q;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_edge_q    <= LOW_EDGE_RST;
			high_edge_q   <= HIGH_EDGE_RST;
			bin_width_q   <= BIN_WIDTH_RST;
			bin_scale_q   <= BIN_SCALE_RST;
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_EDGE:    low_edge_q    <= cfg_data;
				REG_HIGH_EDGE:   high_edge_q   <= cfg_data;
				REG_BIN_WIDTH:   bin_width_q   <= cfg_data;
				REG_BIN_SCALE:   bin_scale_q   <= cfg_data;
				REG_BINS_IN_USE: bins_in_use_q <= cfg_data[NBIN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one bin, anything above the store as the full store
	always_comb begin
		if (bins_in_use_q == '0)
			n_used = NBIN_W'(1);
		else if (bins_in_use_q > NBIN_W'(BINS))
			n_used = NBIN_W'(BINS);
		else
			n_used = bins_in_use_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == IDX_W'(BINS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_RANGE;
			ST_RANGE:  state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_EDGE;
			ST_EDGE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = count_new;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE:   s_tready = 1'b1;
			ST_UPDATE: mem_we   = (func_q == FUNC_INSERT) && hit_q;
			ST_EDGE:   load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
		end
	end

	// bin index and hit, formed in the read step
	always_comb begin
		if (func_q == FUNC_READ) begin
			idx_d = rd_idx_q[IDX_W-1:0];
			hit_d = NBIN_W'(rd_idx_q) < n_used;
		end else begin
			hit_d = in_range_q;
			if (scaled_q >= SCALED_W'(n_used))
				idx_d = IDX_W'(n_used - NBIN_W'(1));
			else
				idx_d = scaled_q[IDX_W-1:0];
		end
	end

	assign prod      = 64'(diff_q) * 64'(bin_scale_q);
	assign eprod     = EPROD_W'(idx_q) * EPROD_W'(bin_width_q);
	assign count_new = (func_q == FUNC_INSERT && rdata_q != '1) ? rdata_q + DATA_W'(1)
		: rdata_q;
	assign edge_val  = $unsigned(low_edge_q) + eprod_q[DATA_W-1:0];

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= s_tuser;
			sample_q <= s_tdata[DATA_W-1:0];
			rd_idx_q <= s_tdata[DATA_W +: RIDX_W];
		end
		if (state_q == ST_RANGE) begin
			in_range_q <= (sample_q >= low_edge_q) && (sample_q < high_edge_q);
			diff_q     <= $unsigned(sample_q - low_edge_q);
		end
		if (state_q == ST_SCALE) scaled_q <= prod[2*DATA_W-1:16];
		if (state_q == ST_READ) begin
			idx_q <= idx_d;
			hit_q <= hit_d;
		end
		if (state_q == ST_UPDATE) begin
			count_q <= count_new;
			eprod_q <= eprod;
		end
	end

	// count store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
		rdata_q <= bin_mem[idx_d];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q   <= hit_q;
			// a missed insert reports bin zero
			out_idx_q   <= (func_q == FUNC_INSERT && !hit_q) ? '0 : idx_q;
			out_count_q <= hit_q ? count_q : '0;
			out_edge_q  <= hit_q ? edge_val : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {6'b0, out_edge_q, out_count_q, out_idx_q};

	`ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !s_tready,
		"item accepted during clearing pass")
	`ASSERT_RST(a_accept_starts_item, accept |=> (state_q == ST_RANGE),
		"accepted item did not start the sequencer")
	`ASSERT_RST(a_write_steps, mem_we |-> (state_q == ST_UPDATE || state_q == ST_CLEAR),
		"count store written outside update or clear")
	`ASSERT_RST(a_count_monotonic, (mem_we && state_q == ST_UPDATE) |-> (mem_wdata >= rdata_q),
		"insert lowered a bin count")
	`ASSERT_RST(a_result_from_edge, $rose(m_tvalid) |-> ($past(state_q) == ST_EDGE),
		"result appeared outside the final step")

endmodule
